@@ hdl/sfq_pkg.sv @@
`timescale 1ns / 1ps

package sfq_pkg;

   localparam int DEPTH    = 16;
   localparam int WORD_W   = 32;
   localparam int CNT_W    = 5;   // count_after field width, holds 0..DEPTH
   localparam int CAP_W    = 5;   // capacity register width
   localparam int CMD_W    = 3;
   localparam int REQ_W    = 40;  // command + value, padded to whole bytes
   localparam int RSP_W    = 40;  // data_out + count + flags, whole bytes
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 3'd0,
      CMD_DEQUEUE = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_UPDATE  = 3'd3,
      CMD_CLEAR   = 3'd4
   } sfq_cmd_type;

   // per-cell strobes: load takes the fresh word, shift takes the neighbour's
   typedef struct packed {
      logic load;
      logic shift;
   } sfq_cell_ctl_type;

endpackage

@@ hdl/sfq_cell.sv @@
`timescale 1ns / 1ps

module sfq_cell
   import sfq_pkg::*;
(
   input  logic                clock,
   input  sfq_cell_ctl_type    ctl,
   input  logic [WORD_W-1:0]   load_word,
   input  logic [WORD_W-1:0]   next_word,   // from the cell one place further back
   output logic [WORD_W-1:0]   word
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.load) begin
         word_in = load_word;
      end else if (ctl.shift) begin
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ hdl/shifting_fifo_queue_top.sv @@
`timescale 1ns / 1ps

// Shifting FIFO of signed 32-bit words, head always in cell 0.
// req_ channel: one command word per handshake (enqueue, dequeue, peek,
//   update head, clear) with a value. rsp_ channel: one result word per
//   command with the head data, the count after the command and the
//   empty / full / took-effect flags.
// csr_ channel: writes the capacity (0..16, larger saturates to 16); the user must
//   write it only while the queue is quiet; the block does not enforce this. csr_ready is always high.
// Timing: the result is registered, so it shows on rsp_ in the cycle after
//   the command is taken. One command per cycle while rsp_ is not stalled; the whole
//   cell row shifts, loads or holds at once for each command.
// Stall: a held result blocks req_tready only until rsp_tready takes it;
//   a result being taken frees the register for the next command at once.
// Reset: count 0, capacity 16, no result pending. Cell contents are not
//   cleared - a cell is only read after it has been written.
module shifting_fifo_queue_top
   import sfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,   // [2:0] command, [34:3] value, rest zero
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // [31:0] data_out, [36:32] count_after,
                                           // [37] is_empty, [38] is_full, [39] took_effect
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CAP_W-1:0]   csr_data     // capacity
);

   logic [CMD_W-1:0]  req_command;
   logic [WORD_W-1:0] req_value;
   logic              req_fire;

   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  cap_eff;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic [WORD_W-1:0] data_out;
   logic              took;
   logic              enq_load;
   logic              upd_load;
   logic              deq_shift;
   logic              is_empty;
   logic              is_full;

   logic [WORD_W-1:0]  cell_word [DEPTH];
   sfq_cell_ctl_type   cell_ctl  [DEPTH];

   assign req_command = req_tdata[CMD_W-1:0];
   assign req_value   = req_tdata[CMD_W+WORD_W-1:CMD_W];

   // output register frees up in the same cycle it is drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign cap_eff = (CNT_W'(cap_ff) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_ff);

   // command decode against the current count
   always_comb begin
      occ_in    = occ_ff;
      data_out  = '0;
      took      = 1'b0;
      enq_load  = 1'b0;
      upd_load  = 1'b0;
      deq_shift = 1'b0;
      case (sfq_cmd_type'(req_command))
         CMD_ENQUEUE: begin
            if (occ_ff < cap_eff) begin
               occ_in   = occ_ff + CNT_W'(1);
               took     = 1'b1;
               enq_load = 1'b1;
            end
         end
         CMD_DEQUEUE: begin
            if (occ_ff != '0) begin
               data_out  = cell_word[0];
               occ_in    = occ_ff - CNT_W'(1);
               took      = 1'b1;
               deq_shift = 1'b1;
            end
         end
         CMD_PEEK: begin
            if (occ_ff != '0) begin
               data_out = cell_word[0];
               took     = 1'b1;
            end
         end
         CMD_UPDATE: begin
            if (occ_ff != '0) begin
               took     = 1'b1;
               upd_load = 1'b1;
            end
         end
         CMD_CLEAR: begin
            occ_in = '0;
            took   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign is_empty = (occ_in == '0);
   assign is_full  = (occ_in >= cap_eff);

   // per-cell strobes; shifting cells past the count is harmless
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_ctl[i].load  = req_fire &&
                             ((enq_load && (occ_ff == CNT_W'(i))) || (upd_load && (i == 0)));
         cell_ctl[i].shift = req_fire && deq_shift;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_tail
         sfq_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[g]),
            .load_word (req_value),
            .next_word (cell_word[g]),
            .word      (cell_word[g])
         );
      end else begin : g_body
         sfq_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[g]),
            .load_word (req_value),
            .next_word (cell_word[g+1]),
            .word      (cell_word[g])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (req_fire) begin
            occ_ff       <= occ_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {took, is_full, is_empty, occ_in, data_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ test/shifting_fifo_queue_top_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the shifting FIFO. Every accepted command word is run
// through a local model of the queue, and the predicted result word is queued
// in order. Each result word taken from rsp_ is compared with the oldest
// prediction, field by field.
module shifting_fifo_queue_top_tb;
   import sfq_pkg::*;

   // command codes beyond CMD_CLEAR; the block must ignore them
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam int RANDOM_BLOCK = 94;     // items per random block; 8 blocks
   localparam int MAX_REPORTS  = 10;

   // One result word, unpacked
   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [CNT_W-1:0]         count;
      logic                     empty;
      logic                     full;
      logic                     took;
   } fifo_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;  // [2:0] command, [34:3] value, rest zero
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;       // [31:0] data_out, [36:32] count_after,
                                        // [37] is_empty, [38] is_full, [39] took_effect
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CAP_W-1:0]   csr_data = '0;   // capacity

   // Model state: cell row, occupancy and the capacity register
   logic signed [WORD_W-1:0] cell_words [DEPTH];
   int unsigned              held_count = 0;
   int unsigned              capacity_setting = CAP_RESET;

   fifo_result_type pending_results [$];   // predictions, oldest first
   int           error_count = 0;
   int           send_idle_pct = 0;     // chance of a gap before each command word
   int           recv_stall_pct = 0;    // chance of rsp_tready low in a cycle

   shifting_fifo_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Model of one command: updates the local queue state, returns the result
   function automatic fifo_result_type apply_command(logic [CMD_W-1:0] cmd,
                                                     logic signed [WORD_W-1:0] value);
      fifo_result_type r;
      int unsigned  lim;
      int unsigned  i;
      r   = '0;
      lim = (capacity_setting > DEPTH) ? DEPTH : capacity_setting;
      case (cmd)
         CMD_ENQUEUE: begin
            if (held_count < lim) begin
               cell_words[held_count] = value;
               held_count++;
               r.took = 1'b1;
            end
         end
         CMD_DEQUEUE: begin
            if (held_count != 0) begin
               r.data = cell_words[0];
               // shift toward the head; the last held cell keeps its stale word
               for (i = 0; i + 1 < held_count; i++)
                  cell_words[i] = cell_words[i + 1];
               held_count--;
               r.took = 1'b1;
            end
         end
         CMD_PEEK: begin
            if (held_count != 0) begin
               r.data = cell_words[0];
               r.took = 1'b1;
            end
         end
         CMD_UPDATE: begin
            if (held_count != 0) begin
               cell_words[0] = value;
               r.took = 1'b1;
            end
         end
         CMD_CLEAR: begin
            held_count = 0;
            r.took = 1'b1;
         end
         default: ;
      endcase
      r.count = CNT_W'(held_count);
      r.empty = (held_count == 0);
      r.full  = (held_count >= lim);
      return r;
   endfunction

   // Drive one command word, with a random gap first; holds valid until taken
   task automatic send_word(logic [CMD_W-1:0] cmd, logic signed [WORD_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, value, cmd};
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(apply_command(cmd, value));
   endtask

   // Stop sending and let every outstanding result word come back
   task automatic drain_queue();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && guard < 100_000) begin
         @(posedge clock);
         guard++;
      end
      // registered result, plus margin
      repeat (3) @(posedge clock);
   endtask

   // Capacity write, only while the block is quiet
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      drain_queue();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do
         @(posedge clock);
      while (!csr_ready);
      capacity_setting = cap;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   // Result checker, and the receiver's stall pattern
   always @(posedge clock) begin : rsp_checker
      fifo_result_type got;
      fifo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data  = rsp_tdata[31:0];
         got.count = rsp_tdata[36:32];
         got.empty = rsp_tdata[37];
         got.full  = rsp_tdata[38];
         got.took  = rsp_tdata[39];
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result word with nothing expected: %h", $realtime, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"%0t: mismatch: exp data %0d count %0d empty %b full %b took %b,",
                            " got data %0d count %0d empty %b full %b took %b"},
                           $realtime, want.data, want.count, want.empty, want.full,
                           want.took, got.data, got.count, got.empty, got.full, got.took);
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Head operations on a queue that is empty, plus the unused command codes
   task automatic test_empty_queue();
      send_word(CMD_PEEK, WORD_MAX);
      send_word(CMD_DEQUEUE, WORD_MIN);
      send_word(CMD_UPDATE, WORD_MAX);
      send_word(CMD_SPARE_LO, WORD_MIN);
      send_word(CMD_SPARE_HI, -1);
   endtask

   // Extreme words through enqueue, update, peek and dequeue
   task automatic test_extreme_words();
      send_word(CMD_ENQUEUE, WORD_MAX);
      send_word(CMD_ENQUEUE, WORD_MIN);
      send_word(CMD_PEEK, '0);
      send_word(CMD_UPDATE, -1);
      send_word(CMD_DEQUEUE, '0);
      send_word(CMD_DEQUEUE, '0);
   endtask

   // Clear on a held queue and on an empty one
   task automatic test_clear();
      send_word(CMD_ENQUEUE, '0);
      send_word(CMD_CLEAR, WORD_MAX);
      send_word(CMD_PEEK, '0);
      send_word(CMD_CLEAR, '0);
   endtask

   // Capacity of zero, full queue, capacity lowered below the count, saturation
   task automatic test_capacity_limits();
      write_capacity(CAP_W'(0));
      send_word(CMD_ENQUEUE, 32'sd17);
      write_capacity(CAP_W'(2));
      send_word(CMD_ENQUEUE, 32'sd1);
      send_word(CMD_ENQUEUE, 32'sd2);
      send_word(CMD_ENQUEUE, 32'sd3);     // dropped, full
      write_capacity(CAP_W'(1));
      send_word(CMD_ENQUEUE, 32'sd4);     // dropped, count above capacity
      send_word(CMD_DEQUEUE, '0);
      send_word(CMD_ENQUEUE, 32'sd5);     // still full at count 1
      send_word(CMD_DEQUEUE, '0);
      write_capacity(CAP_W'(31));         // saturates to DEPTH
      send_word(CMD_ENQUEUE, WORD_MIN);
   endtask

   // Random traffic: mostly fill and drain bursts, with mixed commands between
   task automatic test_random_traffic(int n_items);
      int sent;
      int len;
      int mode;
      int w;
      logic [CMD_W-1:0] cmd;
      sent = 0;
      while (sent < n_items) begin
         mode = $urandom_range(0, 9);
         len  = (mode <= 6) ? $urandom_range(1, 18) : $urandom_range(1, 8);
         if (mode == 9)
            len = 1;
         repeat (len) begin
            if (mode <= 3)
               cmd = CMD_ENQUEUE;
            else if (mode <= 6)
               cmd = CMD_DEQUEUE;
            else if (mode == 9)
               cmd = $urandom_range(0, 1) ? CMD_CLEAR
                                          : CMD_W'($urandom_range(CMD_SPARE_LO,
                                                                  CMD_SPARE_HI));
            else begin
               w = $urandom_range(0, 99);
               if (w < 35)      cmd = CMD_ENQUEUE;
               else if (w < 65) cmd = CMD_DEQUEUE;
               else if (w < 80) cmd = CMD_PEEK;
               else if (w < 95) cmd = CMD_UPDATE;
               else if (w < 98) cmd = CMD_CLEAR;
               else             cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            end
            send_word(cmd, pick_word());
            sent++;
         end
      end
   endtask

   // One random phase: set the idle pattern, then two blocks at two capacities
   task automatic test_random_phase(int idle_pct, int stall_pct,
                                    logic [CAP_W-1:0] cap_a, logic [CAP_W-1:0] cap_b);
      drain_queue();
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      write_capacity(cap_a);
      test_random_traffic(RANDOM_BLOCK);
      write_capacity(cap_b);
      test_random_traffic(RANDOM_BLOCK);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_extreme_words();
      test_clear();
      test_capacity_limits();

      test_random_phase(0, 0, CAP_W'(16), CAP_W'(31));    // no idling
      test_random_phase(87, 0, CAP_W'(5), CAP_W'(1));     // sender idle
      test_random_phase(0, 87, CAP_W'(17), CAP_W'(0));    // receiver stalling
      test_random_phase(24, 24, CAP_W'(8), CAP_W'(16));   // both

      drain_queue();
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0d result words never arrived", pending_results.size());
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ shifting_fifo_queue_top.f @@
hdl/sfq_pkg.sv
hdl/sfq_cell.sv
hdl/shifting_fifo_queue_top.sv
test/shifting_fifo_queue_top_tb.sv
